@@ hdl/hlm_pkg.sv @@
`timescale 1ns / 1ps

package hlm_pkg;

  localparam int MAX_LINES_DEF = 32;

  localparam int SLOT_W    = 6;
  localparam int RHO_W     = 16;
  localparam int THETA_W   = 16;
  localparam int DIM_W     = 12;
  localparam int RTOL_W    = 15;
  localparam int ATOL_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Endpoint coordinates stay well inside 17 signed bits, since the divisor
  // of either branch is at least sin(pi/4) in magnitude.
  localparam int COORD_W = 17;

  localparam int ANG_W        = 24;
  localparam int CS_W         = 33;
  localparam int NUM_W        = 46;
  localparam int DIV_W        = 48;
  localparam int QUO_W        = 16;
  localparam int STEP_W       = 5;
  localparam int CORDIC_STEPS = 20;
  localparam int RHO_SHIFT    = 26;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 24'sd3294199;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 24'sd1647099;
  localparam logic signed [CS_W-1:0]  CORDIC_START = 33'sd652032874;
  localparam logic [THETA_W-1:0]      HORIZ_LOW   = 16'd12868;
  localparam logic [THETA_W-1:0]      HORIZ_HIGH  = 16'd38603;

  localparam logic [DIM_W-1:0]  RST_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 12'd480;
  localparam logic [RTOL_W-1:0] RST_RTOL   = 15'd320;
  localparam logic [ATOL_W-1:0] RST_ATOL   = 16'd2860;
  localparam logic [DIM_W-1:0]  RST_DIST   = 12'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_RHO_TOL      = 3'd2,
    REG_ANGLE_TOL    = 3'd3,
    REG_EP_DIST      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
  } ep_pts_t;

  typedef struct packed {
    logic                      start;
    logic signed [RHO_W-1:0]   rho;
    logic [THETA_W-1:0]        theta;
  } ep_req_t;

  typedef struct packed {
    logic    done;
    ep_pts_t pts;
  } ep_rsp_t;

  typedef enum logic [2:0] {
    EP_IDLE,
    EP_ROT,
    EP_MUL,
    EP_DIV1,
    EP_DIV2,
    EP_DONE
  } ep_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_CHECK,
    ST_C_RD,
    ST_C_EP,
    ST_P_CHECK,
    ST_P_RD,
    ST_P_EP,
    ST_P_SQ,
    ST_O_RD,
    ST_O_EMIT
  } top_state_e;

  // Rotation angles atan(2^-i) in units of 2^-20 rad.
  function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] a;
    case (i)
      5'd0:    a = 24'sd823550;
      5'd1:    a = 24'sd486170;
      5'd2:    a = 24'sd256879;
      5'd3:    a = 24'sd130396;
      5'd4:    a = 24'sd65451;
      5'd5:    a = 24'sd32757;
      5'd6:    a = 24'sd16383;
      5'd7:    a = 24'sd8192;
      5'd8:    a = 24'sd4096;
      5'd9:    a = 24'sd2048;
      5'd10:   a = 24'sd1024;
      5'd11:   a = 24'sd512;
      5'd12:   a = 24'sd256;
      5'd13:   a = 24'sd128;
      5'd14:   a = 24'sd64;
      5'd15:   a = 24'sd32;
      5'd16:   a = 24'sd16;
      5'd17:   a = 24'sd8;
      5'd18:   a = 24'sd4;
      5'd19:   a = 24'sd2;
      default: a = 24'sd0;
    endcase
    return a;
  endfunction

endpackage

@@ hdl/hough_line_merger.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Signals                                   Handshake
// line in   input      rho_i, theta_i, last_line_i               start & !busy
// result    output     slot_o, merged_rho_o, merged_theta_o,     result_valid_o
//                      fused_away_o, last_result_o
// config    input      cfg_idx_i, cfg_wdata_i                    cfg_we_i
//
// A line beat without last_line_i is stored and the block stays idle. The
// beat that carries last_line_i starts the merge; busy stays high until the
// final result. Each live current line takes a check, a read, a pass
// through the shared endpoint unit (20 CORDIC rotations, one multiply, two
// 16-step divisions and a done state) and a write back. A fused current line
// takes only its check. Each other slot takes only a check when it is fused
// or is the current slot, a check and a read when it fails the tolerance
// test, and a check, a read, an endpoint pass and the squarings when its
// endpoints are tested. Each result beat is read out of the line RAM.
// Reset clears the line count, fused marks and registers; the line RAM is
// not cleared, since only slots below the count are read.
// The result receiver cannot stall: every result beat lasts one cycle.

module hough_line_merger #(
  parameter int MAX_LINES = hlm_pkg::MAX_LINES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [hlm_pkg::RHO_W-1:0]   rho_i,
  input  logic [hlm_pkg::THETA_W-1:0]   theta_i,
  input  logic                          last_line_i,
  input  logic                          cfg_we_i,
  input  logic [hlm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hlm_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                          result_valid_o,
  output logic [hlm_pkg::SLOT_W-1:0]    slot_o,
  output logic signed [hlm_pkg::RHO_W-1:0]   merged_rho_o,
  output logic [hlm_pkg::THETA_W-1:0]   merged_theta_o,
  output logic                          fused_away_o,
  output logic                          last_result_o
);

  import hlm_pkg::*;

  localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W = $clog2(MAX_LINES + 1);
  localparam int LW    = RHO_W + THETA_W;
  localparam int OP_W  = COORD_W + 1;
  localparam int SQ_W  = 2 * OP_W;

  // Configuration registers.
  logic [DIM_W-1:0]  width_q, height_q, dist_q;
  logic [RTOL_W-1:0] rtol_q;
  logic [ATOL_W-1:0] atol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      rtol_q   <= RST_RTOL;
      atol_q   <= RST_ATOL;
      dist_q   <= RST_DIST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[DIM_W-1:0];
        REG_RHO_TOL:      rtol_q   <= cfg_wdata_i[RTOL_W-1:0];
        REG_ANGLE_TOL:    atol_q   <= cfg_wdata_i[ATOL_W-1:0];
        REG_EP_DIST:      dist_q   <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  top_state_e state_q, state_d;

  logic [CNT_W-1:0]     count_q, cur_q, pos_q;
  logic [MAX_LINES-1:0] fused_q;
  logic [2:0]           sq_step_q;

  logic signed [RHO_W-1:0] cur_rho_q, cand_rho_q;
  logic [THETA_W-1:0]      cur_theta_q, cand_theta_q;
  ep_pts_t                 pc_q, pp_q;
  logic [SQ_W-1:0]         dd_q, acc_q;
  logic                    near_a_q;

  // Line RAM: rho and theta of each slot side by side.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [LW-1:0]    ram_wdata, ram_rdata;

  hlm_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_LINES)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ep_req_t ep_req;
  ep_rsp_t ep_rsp;

  hlm_endpoint u_endpoint (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ep_req),
    .width_i (width_q),
    .height_i(height_q),
    .rsp_o   (ep_rsp)
  );

  // Datapath around the stored line that was just read.
  logic signed [RHO_W-1:0] rd_rho;
  logic [THETA_W-1:0]      rd_theta;
  logic signed [RHO_W:0]   dr_c, rsum_c;
  logic signed [THETA_W:0] dt_c;
  logic [RHO_W:0]          dr_abs;
  logic [THETA_W:0]        dt_abs, tsum_c;
  logic                    same_c, pass_c;
  logic                    accept, full;
  logic                    cur_fused, pos_skip, out_last;
  logic signed [OP_W-1:0]  sq_op;
  logic signed [SQ_W-1:0]  sq_prod;
  logic [SQ_W-1:0]         sq_c;
  logic [SQ_W:0]           pair_sum;
  logic                    pair_near;

  always_comb begin
    rd_rho   = $signed(ram_rdata[LW-1:THETA_W]);
    rd_theta = ram_rdata[THETA_W-1:0];

    dr_c   = (RHO_W+1)'(rd_rho) - (RHO_W+1)'(cur_rho_q);
    dt_c   = $signed({1'b0, rd_theta}) - $signed({1'b0, cur_theta_q});
    dr_abs = dr_c[RHO_W] ? $unsigned(-dr_c) : $unsigned(dr_c);
    dt_abs = dt_c[THETA_W] ? $unsigned(-dt_c) : $unsigned(dt_c);
    same_c = (rd_rho == cur_rho_q) && (rd_theta == cur_theta_q);
    pass_c = !same_c && (dr_abs < (RHO_W+1)'(rtol_q)) && (dt_abs < (THETA_W+1)'(atol_q));

    // Averages round toward minus infinity.
    rsum_c = (RHO_W+1)'(cur_rho_q) + (RHO_W+1)'(cand_rho_q);
    tsum_c = (THETA_W+1)'(cur_theta_q) + (THETA_W+1)'(cand_theta_q);

    accept    = start && !busy;
    full      = count_q >= CNT_W'(MAX_LINES);
    cur_fused = fused_q[cur_q[IDX_W-1:0]];
    pos_skip  = (pos_q == cur_q) || fused_q[pos_q[IDX_W-1:0]];
    out_last  = (cur_q + 1'b1) == count_q;

    // One squaring a cycle: the distance limit, then the two pairs.
    case (sq_step_q)
      3'd0:    sq_op = $signed(OP_W'(dist_q));
      3'd1:    sq_op = OP_W'(pp_q.x1) - OP_W'(pc_q.x1);
      3'd2:    sq_op = OP_W'(pp_q.y1) - OP_W'(pc_q.y1);
      3'd3:    sq_op = OP_W'(pp_q.x2) - OP_W'(pc_q.x2);
      3'd4:    sq_op = OP_W'(pp_q.y2) - OP_W'(pc_q.y2);
      default: sq_op = '0;
    endcase
    sq_prod   = sq_op * sq_op;
    sq_c      = $unsigned(sq_prod);
    pair_sum  = (SQ_W+1)'(acc_q) + (SQ_W+1)'(sq_c);
    pair_near = pair_sum < (SQ_W+1)'(dd_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (accept && last_line_i) state_d = ST_C_CHECK;
      ST_C_CHECK: begin
        if (cur_q == count_q) begin
          state_d = ST_O_RD;
        end else if (!cur_fused) begin
          state_d = ST_C_RD;
        end
      end
      ST_C_RD:    state_d = ST_C_EP;
      ST_C_EP:    if (ep_rsp.done) state_d = ST_P_CHECK;
      ST_P_CHECK: begin
        if (pos_q == count_q) begin
          state_d = ST_C_CHECK;
        end else if (!pos_skip) begin
          state_d = ST_P_RD;
        end
      end
      ST_P_RD:    state_d = pass_c ? ST_P_EP : ST_P_CHECK;
      ST_P_EP:    if (ep_rsp.done) state_d = ST_P_SQ;
      ST_P_SQ:    if (sq_step_q == 3'd4) state_d = ST_P_CHECK;
      ST_O_RD:    state_d = ST_O_EMIT;
      ST_O_EMIT:  state_d = out_last ? ST_IDLE : ST_O_RD;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[IDX_W-1:0];
    ram_wdata = {rho_i, theta_i};
    ram_raddr = cur_q[IDX_W-1:0];
    ep_req.start = 1'b0;
    ep_req.rho   = rd_rho;
    ep_req.theta = rd_theta;
    result_valid_o = 1'b0;
    case (state_q)
      ST_IDLE:    ram_we = accept && !full;
      ST_P_CHECK: begin
        ram_raddr = pos_q[IDX_W-1:0];
        if (pos_q == count_q) begin
          // The current line goes back with all its merges applied.
          ram_we    = 1'b1;
          ram_waddr = cur_q[IDX_W-1:0];
          ram_wdata = {cur_rho_q, cur_theta_q};
        end
      end
      ST_C_RD:    ep_req.start = 1'b1;
      ST_P_RD:    ep_req.start = pass_c;
      ST_O_EMIT:  result_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign busy           = state_q != ST_IDLE;
  assign slot_o         = SLOT_W'(cur_q);
  assign fused_away_o   = cur_fused;
  assign merged_rho_o   = cur_fused ? '0 : rd_rho;
  assign merged_theta_o = cur_fused ? '0 : rd_theta;
  assign last_result_o  = out_last;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      cur_q     <= '0;
      pos_q     <= '0;
      fused_q   <= '0;
      sq_step_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          cur_q <= '0;
          if (accept && !full) begin
            fused_q[count_q[IDX_W-1:0]] <= 1'b0;
            count_q <= count_q + 1'b1;
          end
        end
        ST_C_CHECK: begin
          if (cur_q == count_q) begin
            cur_q <= '0;
          end else if (cur_fused) begin
            cur_q <= cur_q + 1'b1;
          end
          pos_q <= '0;
        end
        ST_P_CHECK: begin
          if (pos_q == count_q) begin
            cur_q <= cur_q + 1'b1;
          end else if (pos_skip) begin
            pos_q <= pos_q + 1'b1;
          end
          sq_step_q <= '0;
        end
        ST_P_RD:   if (!pass_c) pos_q <= pos_q + 1'b1;
        ST_P_SQ: begin
          sq_step_q <= sq_step_q + 1'b1;
          if (sq_step_q == 3'd4) begin
            if (near_a_q && pair_near) begin
              fused_q[pos_q[IDX_W-1:0]] <= 1'b1;
            end
            pos_q <= pos_q + 1'b1;
          end
        end
        ST_O_EMIT: begin
          if (out_last) begin
            count_q <= '0;
            fused_q <= '0;
            cur_q   <= '0;
          end else begin
            cur_q <= cur_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Line values, endpoints and the distance accumulator.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_C_RD: begin
        cur_rho_q   <= rd_rho;
        cur_theta_q <= rd_theta;
      end
      ST_C_EP:   if (ep_rsp.done) pc_q <= ep_rsp.pts;
      ST_P_RD: begin
        cand_rho_q   <= rd_rho;
        cand_theta_q <= rd_theta;
      end
      ST_P_EP:   if (ep_rsp.done) pp_q <= ep_rsp.pts;
      ST_P_SQ: begin
        case (sq_step_q)
          3'd0:    dd_q <= sq_c;
          3'd1:    acc_q <= sq_c;
          3'd2:    near_a_q <= pair_near;
          3'd3:    acc_q <= sq_c;
          default: begin
            if (near_a_q && pair_near) begin
              cur_rho_q   <= rsum_c[RHO_W:1];
              cur_theta_q <= tsum_c[THETA_W:1];
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_LINES))
    else $error("line count beyond the store depth");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beats are not separated by a read cycle");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(result_valid_o && last_result_o))
    else $error("merge ended without the final result beat");

  a_ep_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ep_rsp.done |-> (state_q == ST_C_EP || state_q == ST_P_EP))
    else $error("endpoint result arrived while nobody waited for it");

endmodule

@@ hdl/hlm_ram.sv @@
`timescale 1ns / 1ps

module hlm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/hlm_endpoint.sv @@
`timescale 1ns / 1ps

module hlm_endpoint (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hlm_pkg::ep_req_t          req_i,
  input  logic [hlm_pkg::DIM_W-1:0] width_i,
  input  logic [hlm_pkg::DIM_W-1:0] height_i,
  output hlm_pkg::ep_rsp_t          rsp_o
);

  import hlm_pkg::*;

  ep_state_e state_q, state_d;

  logic signed [CS_W-1:0]  x_q, y_q;
  logic signed [ANG_W-1:0] z_q;
  logic                    flip_q;
  logic [STEP_W-1:0]       step_q;
  logic signed [RHO_W-1:0] rho_q;
  logic                    horiz_q;
  logic signed [NUM_W-1:0] prod_q;
  logic [DIV_W-1:0]        rem_q, dsh_q;
  logic [QUO_W-1:0]        quo_q;
  logic                    neg_q, dzero_q;
  logic signed [COORD_W-1:0] q1_q;
  ep_pts_t                 pts_q;

  logic signed [ANG_W-1:0] z_in, z_start, atan_c;
  logic                    flip_start;
  logic signed [CS_W-1:0]  dx_c, dy_c, s_c, c_c, den_c, mul_b;
  logic [DIM_W-1:0]        mul_a;
  logic signed [NUM_W-1:0] prod_c, r_c, n2_c, load_num;
  logic [NUM_W-1:0]        num_mag;
  logic [CS_W-1:0]         den_mag;
  logic                    ge_c, last_div;
  logic [DIV_W-1:0]        rem_n;
  logic [QUO_W-1:0]        quo_n;
  logic signed [COORD_W-1:0] coord_c, w_c, h_c;

  always_comb begin
    z_in       = $signed({2'b00, req_i.theta, 6'b000000});
    flip_start = z_in > ANG_HALF_PI;
    z_start    = flip_start ? (ANG_PI - z_in) : z_in;

    dx_c   = y_q >>> step_q;
    dy_c   = x_q >>> step_q;
    atan_c = atan_step(step_q);

    s_c    = y_q;
    c_c    = flip_q ? -x_q : x_q;
    den_c  = horiz_q ? s_c : c_c;
    mul_a  = horiz_q ? width_i : height_i;
    mul_b  = horiz_q ? c_c : s_c;
    prod_c = $signed({1'b0, mul_a}) * mul_b;

    r_c  = {{(NUM_W-RHO_W-RHO_SHIFT){rho_q[RHO_W-1]}}, rho_q, {RHO_SHIFT{1'b0}}};
    n2_c = r_c - prod_q;

    load_num = (state_q == EP_MUL) ? r_c : n2_c;
    num_mag  = load_num[NUM_W-1] ? $unsigned(-load_num) : $unsigned(load_num);
    den_mag  = den_c[CS_W-1] ? $unsigned(-den_c) : $unsigned(den_c);

    ge_c  = rem_q >= dsh_q;
    rem_n = ge_c ? (rem_q - dsh_q) : rem_q;
    quo_n = {quo_q[QUO_W-2:0], ge_c};

    if (dzero_q) begin
      coord_c = '0;
    end else if (neg_q) begin
      coord_c = -$signed({1'b0, quo_n});
    end else begin
      coord_c = $signed({1'b0, quo_n});
    end

    last_div = step_q == STEP_W'(QUO_W-1);
    w_c = $signed(COORD_W'(width_i));
    h_c = $signed(COORD_W'(height_i));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      EP_IDLE: if (req_i.start) state_d = EP_ROT;
      EP_ROT:  if (step_q == STEP_W'(CORDIC_STEPS-1)) state_d = EP_MUL;
      EP_MUL:  state_d = EP_DIV1;
      EP_DIV1: if (last_div) state_d = EP_DIV2;
      EP_DIV2: if (last_div) state_d = EP_DONE;
      EP_DONE: state_d = EP_IDLE;
      default: state_d = EP_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = state_q == EP_DONE;
    rsp_o.pts  = pts_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EP_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      EP_IDLE: begin
        x_q     <= CORDIC_START;
        y_q     <= '0;
        z_q     <= z_start;
        flip_q  <= flip_start;
        step_q  <= '0;
        rho_q   <= req_i.rho;
        horiz_q <= (req_i.theta >= HORIZ_LOW) && (req_i.theta <= HORIZ_HIGH);
      end
      EP_ROT: begin
        if (!z_q[ANG_W-1]) begin
          x_q <= x_q - dx_c;
          y_q <= y_q + dy_c;
          z_q <= z_q - atan_c;
        end else begin
          x_q <= x_q + dx_c;
          y_q <= y_q - dy_c;
          z_q <= z_q + atan_c;
        end
        step_q <= (step_q == STEP_W'(CORDIC_STEPS-1)) ? '0 : step_q + 1'b1;
      end
      EP_MUL: begin
        // The product is registered here and used by the second division.
        prod_q  <= prod_c;
        rem_q   <= DIV_W'(num_mag);
        dsh_q   <= DIV_W'(den_mag) << (QUO_W-1);
        quo_q   <= '0;
        neg_q   <= load_num[NUM_W-1] ^ den_c[CS_W-1];
        dzero_q <= den_mag == '0;
        step_q  <= '0;
      end
      EP_DIV1, EP_DIV2: begin
        if (last_div) begin
          step_q <= '0;
          if (state_q == EP_DIV1) begin
            q1_q    <= coord_c;
            rem_q   <= DIV_W'(num_mag);
            dsh_q   <= DIV_W'(den_mag) << (QUO_W-1);
            quo_q   <= '0;
            neg_q   <= load_num[NUM_W-1] ^ den_c[CS_W-1];
            dzero_q <= den_mag == '0;
          end else if (horiz_q) begin
            pts_q <= '{x1: '0, y1: q1_q, x2: w_c, y2: coord_c};
          end else begin
            pts_q <= '{x1: q1_q, y1: '0, x2: coord_c, y2: h_c};
          end
        end else begin
          rem_q  <= rem_n;
          dsh_q  <= dsh_q >> 1;
          quo_q  <= quo_n;
          step_q <= step_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the Hough line merger. Lines are sent in sets: each
// set ends with a line beat that carries last_line_i, which makes the block
// merge the stored lines and emit one result beat per loaded slot. A small
// scoreboard keeps its own copy of the line store and the registers and
// predicts every result beat. Each beat seen on the result port is compared
// field by field with the oldest prediction.

typedef struct {
  logic [hlm_pkg::SLOT_W-1:0]         slot;
  logic signed [hlm_pkg::RHO_W-1:0]   rho;
  logic [hlm_pkg::THETA_W-1:0]        theta;
  logic                               fused;
  logic                               last;
} merged_line_t;

class line_merge_sb;
  localparam int DEPTH = hlm_pkg::MAX_LINES_DEF;

  // Rotation angles atan(2^-i), in units of 2^-20 rad.
  longint rot_angle[hlm_pkg::CORDIC_STEPS] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  longint width_px, height_px, rho_tol, ang_tol, near_dist;
  longint line_rho[DEPTH];
  longint line_theta[DEPTH];
  bit     absorbed[DEPTH];
  int     n_lines;
  merged_line_t merged_q[$];
  int     errors;
  int     n_beats;
  int     n_sets;
  int     n_fused;

  function new();
    width_px  = hlm_pkg::RST_WIDTH;
    height_px = hlm_pkg::RST_HEIGHT;
    rho_tol   = hlm_pkg::RST_RTOL;
    ang_tol   = hlm_pkg::RST_ATOL;
    near_dist = hlm_pkg::RST_DIST;
    n_lines   = 0;
    errors    = 0;
  endfunction

  function void set_reg(hlm_pkg::cfg_reg_e idx, logic [hlm_pkg::CFG_W-1:0] val);
    case (idx)
      hlm_pkg::REG_IMAGE_WIDTH:  width_px  = val[hlm_pkg::DIM_W-1:0];
      hlm_pkg::REG_IMAGE_HEIGHT: height_px = val[hlm_pkg::DIM_W-1:0];
      hlm_pkg::REG_RHO_TOL:      rho_tol   = val[hlm_pkg::RTOL_W-1:0];
      hlm_pkg::REG_ANGLE_TOL:    ang_tol   = val[hlm_pkg::ATOL_W-1:0];
      hlm_pkg::REG_EP_DIST:      near_dist = val[hlm_pkg::DIM_W-1:0];
      default: ;
    endcase
  endfunction

  // Rotation CORDIC; arithmetic right shifts of signed values round to minus infinity.
  function void sin_cos(longint th, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = th * 64;
    x = hlm_pkg::CORDIC_START;
    y = 0;
    flip = 0;
    if (z > hlm_pkg::ANG_HALF_PI) begin
      z = hlm_pkg::ANG_PI - z;
      flip = 1;
    end
    for (int i = 0; i < hlm_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= rot_angle[i];
      end else begin
        x += dx; y -= dy; z += rot_angle[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function longint div0(longint n, longint d);
    return (d == 0) ? 0 : n / d;
  endfunction

  function void frame_points(longint rho, longint th, output longint pt[4]);
    longint s, c, r;
    r = rho * 64'sd67108864;
    sin_cos(th, s, c);
    if (th >= hlm_pkg::HORIZ_LOW && th <= hlm_pkg::HORIZ_HIGH) begin
      pt[0] = 0;
      pt[1] = div0(r, s);
      pt[2] = width_px;
      pt[3] = div0(r - width_px * c, s);
    end else begin
      pt[0] = div0(r, c);
      pt[1] = 0;
      pt[2] = div0(r - height_px * s, c);
      pt[3] = height_px;
    end
  endfunction

  function bit close_by(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy < near_dist * near_dist;
  endfunction

  function void merge_lines();
    longint pc[4], pp[4], dr, dt;
    for (int cur = 0; cur < n_lines; cur++) begin
      if (absorbed[cur]) continue;
      frame_points(line_rho[cur], line_theta[cur], pc);
      for (int p = 0; p < n_lines; p++) begin
        if (absorbed[p]) continue;
        if (line_rho[p] == line_rho[cur] && line_theta[p] == line_theta[cur]) continue;
        dr = line_rho[p] - line_rho[cur];
        dt = line_theta[p] - line_theta[cur];
        if (dr < 0) dr = -dr;
        if (dt < 0) dt = -dt;
        if (!(dr < rho_tol && dt < ang_tol)) continue;
        frame_points(line_rho[p], line_theta[p], pp);
        if (close_by(pp[0], pp[1], pc[0], pc[1]) && close_by(pp[2], pp[3], pc[2], pc[3]))
        begin
          line_rho[cur]   = (line_rho[cur] + line_rho[p]) >>> 1;
          line_theta[cur] = (line_theta[cur] + line_theta[p]) >> 1;
          absorbed[p] = 1;
        end
      end
    end
  endfunction

  // Called for every accepted line beat.
  function void note_line(logic signed [15:0] rho, logic [15:0] th, logic last);
    merged_line_t m;
    if (n_lines < DEPTH) begin
      line_rho[n_lines]   = rho;
      line_theta[n_lines] = th;
      absorbed[n_lines]   = 0;
      n_lines++;
    end
    if (!last) return;
    merge_lines();
    for (int k = 0; k < n_lines; k++) begin
      m.slot  = k;
      m.fused = absorbed[k];
      m.rho   = absorbed[k] ? '0 : line_rho[k][15:0];
      m.theta = absorbed[k] ? '0 : line_theta[k][15:0];
      m.last  = (k + 1 == n_lines);
      if (absorbed[k]) n_fused++;
      merged_q.push_back(m);
    end
    n_lines = 0;
    n_sets++;
  endfunction

  function void check_result(merged_line_t got);
    merged_line_t want;
    n_beats++;
    if (merged_q.size() == 0) begin
      $display("%0t: unexpected result beat, slot %0d", $time, got.slot);
      errors++;
      return;
    end
    want = merged_q.pop_front();
    if (got.slot !== want.slot) begin
      $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
      errors++;
    end
    if (got.rho !== want.rho) begin
      $display("%0t: slot %0d merged_rho expected %0d actual %0d",
               $time, want.slot, want.rho, got.rho);
      errors++;
    end
    if (got.theta !== want.theta) begin
      $display("%0t: slot %0d merged_theta expected %0d actual %0d",
               $time, want.slot, want.theta, got.theta);
      errors++;
    end
    if (got.fused !== want.fused) begin
      $display("%0t: slot %0d fused_away expected %0b actual %0b",
               $time, want.slot, want.fused, got.fused);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t: slot %0d last_result expected %0b actual %0b",
               $time, want.slot, want.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import hlm_pkg::*;

  // An index past the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd5;
  // A merge runs with no beat moving; the limit covers the worst merge.
  localparam int STALL_LIMIT = 300000;
  localparam int RANDOM_LINES = 120;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [RHO_W-1:0] rho_i = '0;
  logic [THETA_W-1:0] theta_i = '0;
  logic last_line_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic result_valid_o;
  logic [SLOT_W-1:0] slot_o;
  logic signed [RHO_W-1:0] merged_rho_o;
  logic [THETA_W-1:0] merged_theta_o;
  logic fused_away_o;
  logic last_result_o;

  line_merge_sb sb = new();
  int stall_cycles = 0;
  int lines_sent = 0;
  bit quiet_tail = 0;

  always #1 clk_i = ~clk_i;

  hough_line_merger dut (
    .clk_i, .rst_ni, .start, .busy, .rho_i, .theta_i, .last_line_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .result_valid_o, .slot_o,
    .merged_rho_o, .merged_theta_o, .fused_away_o, .last_result_o
  );

  // Result beats last exactly one cycle, so every valid cycle is checked.
  // The watchdog counts cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result('{slot: slot_o, rho: merged_rho_o, theta: merged_theta_o,
                        fused: fused_away_o, last: last_result_o});
    end
    if (rst_ni && (result_valid_o || (start && !busy))) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive one line beat and hold it until the block takes it. start is
  // left high, so back-to-back beats never lower and raise it in one step.
  task automatic send_line(logic signed [RHO_W-1:0] rho, logic [THETA_W-1:0] th,
                           logic last);
    @(negedge clk_i);
    rho_i = rho;
    theta_i = th;
    last_line_i = last;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_line(rho, th, last);
    lines_sent++;
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk_i);
    start = 1'b0;
    rho_i = $urandom;
    theta_i = $urandom;
    last_line_i = $urandom_range(0, 1);
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Random sender gaps, skipped in the closing stretch of the run.
  task automatic maybe_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 14));
  endtask

  // Sender waits for every predicted result, then for the block to go idle.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.merged_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    if (idx <= REG_EP_DIST) sb.set_reg(cfg_reg_e'(idx), val);
  endtask

  task automatic set_regs(int w, int h, int rt, int at, int d);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_RHO_TOL, rt);
    write_reg(REG_ANGLE_TOL, at);
    write_reg(REG_EP_DIST, d);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // A set built around a few random base lines, each followed by near copies
  // so that the merge path is exercised, with some stray lines mixed in.
  task automatic send_cluster_set(int n);
    logic signed [RHO_W-1:0] base_rho, r;
    logic [THETA_W-1:0] base_th, t;
    base_rho = $urandom_range(0, 12000) - 6000;
    base_th = $urandom_range(0, 51471);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        base_rho = $urandom_range(0, 12000) - 6000;
        base_th = $urandom_range(0, 51471);
      end
      if ($urandom_range(0, 7) == 0) begin
        r = $urandom;
        t = $urandom;
      end else begin
        r = base_rho + $signed($urandom_range(0, 160)) - 80;
        t = base_th + $urandom_range(0, 600) - 300;
      end
      send_line(r, t, i == n - 1);
      maybe_gap();
    end
  endtask

  initial begin
    int phase;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, the horizontal band borders, duplicates,
    // a close pair, and an out-of-range theta, under reset settings.
    send_line(-16'sd32768, 16'd0, 1'b0);
    send_line(16'sd32767, 16'd51471, 1'b0);
    send_line(16'sd0, 16'hFFFF, 1'b0);
    send_line(16'sd1600, 16'd12868, 1'b0);
    send_line(16'sd1600, 16'd12868, 1'b0);
    send_line(16'sd1620, 16'd12900, 1'b0);
    send_line(16'sd800, 16'd12867, 1'b0);
    send_line(16'sd800, 16'd38603, 1'b0);
    send_line(16'sd810, 16'd38604, 1'b0);
    send_line(16'sd3000, 16'd25735, 1'b1);
    hold_off(3);
    send_line(-16'sd1, 16'd100, 1'b1);
    drain();

    // Smallest frame and zero tolerances: nothing may merge.
    set_regs(1, 1, 0, 0, 0);
    write_reg(REG_NONE, 16'hFFFF);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    send_line(16'sd100, 16'd200, 1'b0);
    send_line(16'sd101, 16'd201, 1'b0);
    send_line(-16'sd5, 16'd0, 1'b1);
    drain();

    // Largest settings: merging is as permissive as it gets.
    set_regs(4095, 4095, 32767, 65535, 4095);
    send_line(16'sd0, 16'd0, 1'b0);
    send_line(16'sd40, 16'd10, 1'b0);
    send_line(-16'sd40, 16'd51471, 1'b0);
    send_line(16'sd16000, 16'd25000, 1'b1);
    drain();

    // Store overflow: the lines past the last slot are dropped.
    set_regs(640, 480, 320, 2860, 64);
    for (int i = 0; i < MAX_LINES_DEF + 2; i++) begin
      send_line($urandom, $urandom, i == MAX_LINES_DEF + 1);
    end
    drain();

    // Random sets under a rotation of settings, the defaults among them.
    phase = 0;
    while (lines_sent < RANDOM_LINES) begin
      if (lines_sent > RANDOM_LINES - 30) quiet_tail = 1;
      if (phase % 3 == 2) begin
        drain();
        set_regs($urandom_range(1, 4095), $urandom_range(1, 4095),
                 $urandom_range(0, 32767), $urandom_range(0, 65535),
                 $urandom_range(0, 4095));
      end else if (phase % 3 == 1) begin
        drain();
        set_regs($urandom_range(200, 2000), $urandom_range(200, 2000),
                 $urandom_range(100, 800), $urandom_range(500, 4000),
                 $urandom_range(20, 200));
      end
      send_cluster_set($urandom_range(1, 9));
      phase++;
    end
    drain();

    repeat (50) @(posedge clk_i);
    $display("Covered %0d line beats in %0d sets, %0d result beats, %0d lines fused.",
             lines_sent, sb.n_sets, sb.n_beats, sb.n_fused);
    $display("Register settings ranged from the minimum to the maximum of each field.");
    if (sb.errors == 0 && sb.merged_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (sb.merged_q.size() != 0)
        $display("%0t: %0d predicted results never arrived", $time, sb.merged_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/hlm_pkg.sv
hdl/hlm_ram.sv
hdl/hlm_endpoint.sv
hdl/hough_line_merger.sv
test/tb_top.sv
